// ===== rtl/esc_pkg.sv =====
// esc_pkg: shared types and character codes for the escape sequence unescaper
// no dependencies; used by esc_decode, esc_outq and escape_sequence_unescaper
package esc_pkg;

	localparam logic [7:0] CHR_BSL   = 8'h5C;  // backslash
	localparam logic [7:0] CHR_CARET = 8'h5E;  // caret
	localparam logic [7:0] CHR_QMARK = 8'h3F;  // question mark
	localparam logic [7:0] CHR_DEL   = 8'h7F;  // caret-question result
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_SEVEN = 8'h37;
	localparam logic [7:0] CHR_UC_A  = 8'h41;
	localparam logic [7:0] CHR_UC_Z  = 8'h5A;
	localparam logic [7:0] CHR_LC_A  = 8'h61;
	localparam logic [7:0] CHR_LC_Z  = 8'h7A;
	localparam logic [7:0] CHR_UC_E  = 8'h45;
	localparam logic [7:0] CHR_LC_B  = 8'h62;
	localparam logic [7:0] CHR_LC_E  = 8'h65;
	localparam logic [7:0] CHR_LC_N  = 8'h6E;
	localparam logic [7:0] CHR_LC_R  = 8'h72;
	localparam logic [7:0] CHR_LC_T  = 8'h74;

	localparam logic [7:0] CODE_BEL = 8'h07;
	localparam logic [7:0] CODE_BS  = 8'h08;
	localparam logic [7:0] CODE_ESC = 8'h1B;
	localparam logic [7:0] CODE_LF  = 8'h0A;
	localparam logic [7:0] CODE_CR  = 8'h0D;
	localparam logic [7:0] CODE_TAB = 8'h09;

	// output queue depth, also the most results one byte can produce
	localparam int QDEPTH = 2;

	typedef enum logic [4:0] {
		MODE_NORMAL = 5'b00001,
		MODE_BSL    = 5'b00010,
		MODE_CARET  = 5'b00100,
		MODE_OCT1   = 5'b01000,
		MODE_OCT2   = 5'b10000
	} mode_t;

	// results of decoding one raw byte
	typedef struct packed {
		logic [1:0] cnt;   // 0, 1 or 2 results
		logic [7:0] b0;    // first result
		logic [7:0] b1;    // second result
		logic       last;  // final result carries the end-of-string mark
	} result_t;

endpackage

// ===== rtl/escape_sequence_unescaper.sv =====
// escape_sequence_unescaper: backslash and caret escape decoder, top level
// a byte is registered, decoded and queued; results leave from the result queue
// throughput: one byte per cycle while out_stall is low and it yields zero or one result; a byte
//   yielding two waits until the single output port has drained the two-entry result queue
// reset: arst_n clears decode mode, octal value, input register and result queue
// depends on esc_pkg, esc_decode, esc_outq
module escape_sequence_unescaper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);

	// input register stage
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	esc_pkg::result_t res;
	logic [1:0]       free;
	logic             fire;

	// the registered byte moves on once the queue has room for all its results
	assign fire     = valid_s1 && (res.cnt <= free);
	assign in_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// payload only loads on a transfer
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// escape state machine, advances only when the byte is consumed
	esc_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_i (byte_s1),
		.last_i (last_s1),
		.fire   (fire),
		.res    (res)
	);

	// result queue drives the output channel one byte per transfer
	esc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.res       (res),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

// ===== rtl/esc_decode.sv =====
// esc_decode: escape state machine and per-byte decode logic
// depends on esc_pkg
module esc_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          byte_i,
	input  logic                last_i,
	input  logic                fire,
	output esc_pkg::result_t    res
);

	esc_pkg::mode_t mode_q, mode_d;
	logic [7:0]     oct_q, oct_d;
	logic           is_oct, is_letter;

	assign is_oct = (byte_i >= esc_pkg::CHR_ZERO) && (byte_i <= esc_pkg::CHR_SEVEN);
	assign is_letter = ((byte_i >= esc_pkg::CHR_UC_A) && (byte_i <= esc_pkg::CHR_UC_Z)) ||
	                   ((byte_i >= esc_pkg::CHR_LC_A) && (byte_i <= esc_pkg::CHR_LC_Z));

	always_comb begin
		logic [7:0] tail;
		logic       has_tail;
		res      = '0;
		mode_d   = mode_q;
		oct_d    = oct_q;
		tail     = '0;
		has_tail = 1'b0;
		unique case (mode_q)
			esc_pkg::MODE_BSL: begin
				mode_d  = esc_pkg::MODE_NORMAL;
				res.cnt = 2'd1;
				if (is_oct) begin
					oct_d   = {5'd0, byte_i[2:0]};
					mode_d  = esc_pkg::MODE_OCT1;
					res.cnt = 2'd0;
				end else if (byte_i == esc_pkg::CHR_LC_A) begin
					res.b0 = esc_pkg::CODE_BEL;
				end else if (byte_i == esc_pkg::CHR_LC_B) begin
					res.b0 = esc_pkg::CODE_BS;
				end else if (byte_i == esc_pkg::CHR_LC_E || byte_i == esc_pkg::CHR_UC_E) begin
					res.b0 = esc_pkg::CODE_ESC;
				end else if (byte_i == esc_pkg::CHR_LC_N) begin
					res.b0 = esc_pkg::CODE_LF;
				end else if (byte_i == esc_pkg::CHR_LC_R) begin
					res.b0 = esc_pkg::CODE_CR;
				end else if (byte_i == esc_pkg::CHR_LC_T) begin
					res.b0 = esc_pkg::CODE_TAB;
				end else if (byte_i == esc_pkg::CHR_BSL || byte_i == esc_pkg::CHR_CARET) begin
					res.b0 = byte_i;
				end else begin
					res.b0  = esc_pkg::CHR_BSL;
					res.b1  = byte_i;
					res.cnt = 2'd2;
				end
			end
			esc_pkg::MODE_CARET: begin
				mode_d  = esc_pkg::MODE_NORMAL;
				res.cnt = 2'd1;
				if (byte_i == esc_pkg::CHR_QMARK) begin
					res.b0 = esc_pkg::CHR_DEL;
				end else if (is_letter) begin
					// a letter of either case maps to its low five bits, the uppercase letter minus '@'
					res.b0 = {3'd0, byte_i[4:0]};
				end else begin
					res.b0  = esc_pkg::CHR_CARET;
					res.b1  = byte_i;
					res.cnt = 2'd2;
				end
			end
			esc_pkg::MODE_OCT1, esc_pkg::MODE_OCT2: begin
				if (is_oct) begin
					oct_d = {oct_q[4:0], byte_i[2:0]};
					if (mode_q == esc_pkg::MODE_OCT2) begin
						res.b0  = {oct_q[4:0], byte_i[2:0]};
						res.cnt = 2'd1;
						mode_d  = esc_pkg::MODE_NORMAL;
					end else begin
						mode_d = esc_pkg::MODE_OCT2;
					end
				end else begin
					// flush pending value, then treat the byte as in normal mode
					res.b0  = oct_q;
					res.cnt = 2'd1;
					if (byte_i == esc_pkg::CHR_BSL) begin
						mode_d = esc_pkg::MODE_BSL;
					end else if (byte_i == esc_pkg::CHR_CARET) begin
						mode_d = esc_pkg::MODE_CARET;
					end else begin
						mode_d  = esc_pkg::MODE_NORMAL;
						res.b1  = byte_i;
						res.cnt = 2'd2;
					end
				end
			end
			default: begin
				if (byte_i == esc_pkg::CHR_BSL) begin
					mode_d = esc_pkg::MODE_BSL;
				end else if (byte_i == esc_pkg::CHR_CARET) begin
					mode_d = esc_pkg::MODE_CARET;
				end else begin
					mode_d  = esc_pkg::MODE_NORMAL;
					res.b0  = byte_i;
					res.cnt = 2'd1;
				end
			end
		endcase

		if (last_i) begin
			priority if (mode_d == esc_pkg::MODE_BSL) begin
				tail     = esc_pkg::CHR_BSL;
				has_tail = 1'b1;
			end else if (mode_d == esc_pkg::MODE_CARET) begin
				tail     = esc_pkg::CHR_CARET;
				has_tail = 1'b1;
			end else if (mode_d == esc_pkg::MODE_OCT1 || mode_d == esc_pkg::MODE_OCT2) begin
				tail     = oct_d;
				has_tail = 1'b1;
			end else begin
				has_tail = 1'b0;
			end
			if (has_tail) begin
				if (res.cnt == 2'd0) begin
					res.b0 = tail;
				end else begin
					res.b1 = tail;
				end
				res.cnt = res.cnt + 2'd1;
			end
			res.last = 1'b1;
			mode_d   = esc_pkg::MODE_NORMAL;
			oct_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= esc_pkg::MODE_NORMAL;
			oct_q  <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			oct_q  <= oct_d;
		end
	end

	// end of string always produces a result and returns to normal mode
	a_last_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_i |-> res.cnt != 2'd0)
		else $error("string end produced no result");
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_i |=> mode_q == esc_pkg::MODE_NORMAL && oct_q == 8'd0)
		else $error("state not cleared after string end");
	a_mode_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(mode_q))
		else $error("decode mode not one-hot");

endmodule

// ===== rtl/esc_outq.sv =====
// esc_outq: two-entry result queue between decode and the output channel
// depends on esc_pkg
module esc_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  esc_pkg::result_t res,
	output logic [1:0]       free,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_byte,
	output logic             out_last
);

	logic [7:0] byte_q [esc_pkg::QDEPTH];
	logic       last_q [esc_pkg::QDEPTH];
	logic [7:0] byte_d [esc_pkg::QDEPTH];
	logic       last_d [esc_pkg::QDEPTH];
	logic [1:0] cnt_q, cnt_d, base;
	logic       pop;

	assign pop       = out_valid && !out_stall;
	assign out_valid = cnt_q != 2'd0;
	assign out_byte  = byte_q[0];
	assign out_last  = last_q[0];
	assign free      = 2'(esc_pkg::QDEPTH) - cnt_q + {1'b0, pop};
	assign base      = cnt_q - {1'b0, pop};

	always_comb begin
		byte_d[0] = pop ? byte_q[1] : byte_q[0];
		last_d[0] = pop ? last_q[1] : last_q[0];
		byte_d[1] = byte_q[1];
		last_d[1] = last_q[1];
		cnt_d     = base;
		if (push && res.cnt != 2'd0) begin
			if (base == 2'd0) begin
				byte_d[0] = res.b0;
				last_d[0] = res.last && (res.cnt == 2'd1);
				byte_d[1] = res.b1;
				last_d[1] = res.last;
			end else begin
				byte_d[1] = res.b0;
				last_d[1] = res.last;
			end
			cnt_d = base + res.cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < esc_pkg::QDEPTH; i++) begin
			byte_q[i] <= byte_d[i];
			last_q[i] <= last_d[i];
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(esc_pkg::QDEPTH))
		else $error("result queue overflow");
	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> res.cnt <= free)
		else $error("push exceeds free queue space");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("stalled output changed");

endmodule

// ===== test/unescape_checker.sv =====
// unescape_checker: watches both channels of the escape sequence unescaper,
// predicts decoded bytes and compares every output transfer against them
// depends on esc_pkg
module unescape_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_byte,
	input  logic       out_last,
	output int         fail_count,
	output int         pending,
	output int         decoded_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] CASE_GAP  = 8'h20;  // lower to upper case
	localparam logic [7:0] CTRL_BIAS = 8'h40;  // caret letter to control code

	typedef struct packed {
		logic [7:0] data;
		logic       eos;
	} decoded_t;

	decoded_t       decoded_q[$];
	logic [7:0]     step_bytes[$];
	esc_pkg::mode_t mode;
	logic [7:0]     oct_acc;

	function automatic bit is_octal(input logic [7:0] b);
		return (b >= esc_pkg::CHR_ZERO) && (b <= esc_pkg::CHR_SEVEN);
	endfunction

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("%0t unescape mismatch: %s", $time, what);
	endtask

	// byte in normal mode: open an escape or pass through
	function automatic void start_or_pass(input logic [7:0] b);
		if (b == esc_pkg::CHR_BSL)
			mode = esc_pkg::MODE_BSL;
		else if (b == esc_pkg::CHR_CARET)
			mode = esc_pkg::MODE_CARET;
		else begin
			mode = esc_pkg::MODE_NORMAL;
			step_bytes.push_back(b);
		end
	endfunction

	function automatic void decode_char(input logic [7:0] b, input logic eos);
		logic [7:0] up;
		decoded_t d;
		step_bytes.delete();
		case (mode)
		esc_pkg::MODE_BSL: begin
			mode = esc_pkg::MODE_NORMAL;
			if (is_octal(b)) begin
				oct_acc = b - esc_pkg::CHR_ZERO;
				mode = esc_pkg::MODE_OCT1;
			end else if (b == esc_pkg::CHR_LC_A)
				step_bytes.push_back(esc_pkg::CODE_BEL);
			else if (b == esc_pkg::CHR_LC_B)
				step_bytes.push_back(esc_pkg::CODE_BS);
			else if (b == esc_pkg::CHR_LC_E || b == esc_pkg::CHR_UC_E)
				step_bytes.push_back(esc_pkg::CODE_ESC);
			else if (b == esc_pkg::CHR_LC_N)
				step_bytes.push_back(esc_pkg::CODE_LF);
			else if (b == esc_pkg::CHR_LC_R)
				step_bytes.push_back(esc_pkg::CODE_CR);
			else if (b == esc_pkg::CHR_LC_T)
				step_bytes.push_back(esc_pkg::CODE_TAB);
			else if (b == esc_pkg::CHR_BSL || b == esc_pkg::CHR_CARET)
				step_bytes.push_back(b);
			else begin
				step_bytes.push_back(esc_pkg::CHR_BSL);
				step_bytes.push_back(b);
			end
		end
		esc_pkg::MODE_CARET: begin
			mode = esc_pkg::MODE_NORMAL;
			up = (b >= esc_pkg::CHR_LC_A && b <= esc_pkg::CHR_LC_Z) ? b - CASE_GAP : b;
			if (b == esc_pkg::CHR_QMARK)
				step_bytes.push_back(esc_pkg::CHR_DEL);
			else if (up >= esc_pkg::CHR_UC_A && up <= esc_pkg::CHR_UC_Z)
				step_bytes.push_back(up - CTRL_BIAS);
			else begin
				step_bytes.push_back(esc_pkg::CHR_CARET);
				step_bytes.push_back(b);
			end
		end
		esc_pkg::MODE_OCT1, esc_pkg::MODE_OCT2: begin
			if (is_octal(b)) begin
				oct_acc = (oct_acc << 3) + (b - esc_pkg::CHR_ZERO);
				if (mode == esc_pkg::MODE_OCT2) begin
					step_bytes.push_back(oct_acc);
					mode = esc_pkg::MODE_NORMAL;
				end else
					mode = esc_pkg::MODE_OCT2;
			end else begin
				step_bytes.push_back(oct_acc);
				start_or_pass(b);
			end
		end
		default: start_or_pass(b);
		endcase
		if (eos) begin
			case (mode)
			esc_pkg::MODE_BSL: step_bytes.push_back(esc_pkg::CHR_BSL);
			esc_pkg::MODE_CARET: step_bytes.push_back(esc_pkg::CHR_CARET);
			esc_pkg::MODE_OCT1, esc_pkg::MODE_OCT2: step_bytes.push_back(oct_acc);
			default: ;
			endcase
			mode = esc_pkg::MODE_NORMAL;
			oct_acc = '0;
		end
		foreach (step_bytes[i]) begin
			d.data = step_bytes[i];
			d.eos = eos && (i == step_bytes.size() - 1);
			decoded_q.push_back(d);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		if (!arst_n) begin
			decoded_q.delete();
			mode = esc_pkg::MODE_NORMAL;
			oct_acc = '0;
			pending = 0;
		end else begin
			// results first: a byte taken at this edge cannot have produced one yet
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				decoded_count++;
				if (decoded_q.size() == 0)
					report_mismatch($sformatf("byte %02h last %b with nothing expected",
						out_byte, out_last));
				else begin
					want = decoded_q.pop_front();
					if (out_byte !== want.data)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							out_byte, want.data));
					if (out_last !== want.eos)
						report_mismatch($sformatf("out_last %b, expected %b on byte %02h",
							out_last, want.eos, want.data));
				end
			end
			if (in_valid === 1'b1 && in_stall === 1'b0)
				decode_char(in_byte, in_last);
			pending = decoded_q.size();
		end
	end

endmodule

// ===== test/escape_sequence_unescaper_tb.sv =====
// escape_sequence_unescaper_tb: stimulus and verdict for the escape sequence unescaper
// depends on esc_pkg, escape_sequence_unescaper and unescape_checker
module escape_sequence_unescaper_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PERIOD        = 10;
	localparam int ITEM_TARGET   = 800;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int IDLE_PCT      = 15;
	localparam int QUIET_FROM    = 250;   // no idling or stalling in this byte window
	localparam int QUIET_TO      = 450;
	localparam int DRAIN_AT      = 550;   // sender holds off here until all results are in
	localparam int SETTLE_CYCLES = 8;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       in_last;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       out_last;

	int fail_count;
	int pending;
	int decoded_count;
	int bytes_sent;
	int strings_sent;
	int cycle_count;
	bit quiet;
	bit drained;
	logic [7:0] raw_q[$];

	always #(PERIOD / 2) clk = ~clk;

	escape_sequence_unescaper DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.out_last (out_last)
	);

	unescape_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.in_last      (in_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.out_last     (out_last),
		.fail_count   (fail_count),
		.pending      (pending),
		.decoded_count(decoded_count)
	);

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("escape_sequence_unescaper_tb: errors");
			$finish;
		end
	end

	// receiver stalls at random outside the quiet window
	always @(negedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
	end

	// one byte transfer, with an optional idle gap in front of it
	task automatic send_char(input logic [7:0] b, input logic eos);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= eos;
		// hold the payload until the transfer happens
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
		@(negedge clk);
	endtask

	// whole string, end mark on its final byte
	task automatic send_string();
		foreach (raw_q[i])
			send_char(raw_q[i], i == raw_q.size() - 1);
		strings_sent++;
	endtask

	initial begin
		int kind;
		int ntok;
		int ndig;
		logic [7:0] b;

		in_valid = 1'b0;
		in_byte = '0;
		in_last = 1'b0;
		arst_n = 1'b0;
		quiet = 1'b0;
		drained = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// field extremes, \n, ^?, three-digit octal that wraps past 255
		raw_q = '{8'h01, 8'hFF, esc_pkg::CHR_BSL, esc_pkg::CHR_LC_N,
			esc_pkg::CHR_CARET, esc_pkg::CHR_QMARK, esc_pkg::CHR_BSL,
			esc_pkg::CHR_ZERO + 8'd4, esc_pkg::CHR_ZERO, esc_pkg::CHR_ZERO + 8'd1};
		send_string();
		// octal run cut by a plain byte, lower-case caret letter, lone backslash at end
		raw_q = '{esc_pkg::CHR_BSL, esc_pkg::CHR_SEVEN, 8'h78, esc_pkg::CHR_CARET, 8'h71,
			esc_pkg::CHR_BSL};
		send_string();
		// escaped backslash, caret before a non-letter, lone caret at end
		raw_q = '{esc_pkg::CHR_BSL, esc_pkg::CHR_BSL, esc_pkg::CHR_CARET, 8'h23,
			esc_pkg::CHR_CARET};
		send_string();
		// octal value still pending when the string ends
		raw_q = '{esc_pkg::CHR_BSL, esc_pkg::CHR_ZERO + 8'd1, esc_pkg::CHR_ZERO + 8'd2};
		send_string();
		// zero byte on its own
		raw_q = '{8'h00};
		send_string();

		// random strings built from tokens: plain bytes, well-formed escapes, escapes before any byte, lone escapes
		while (bytes_sent < ITEM_TARGET) begin
			quiet = (bytes_sent >= QUIET_FROM) && (bytes_sent < QUIET_TO);
			if (!drained && bytes_sent >= DRAIN_AT) begin
				in_valid <= 1'b0;
				do
					@(negedge clk);
				while (pending != 0);
				drained = 1'b1;
			end
			raw_q.delete();
			ntok = $urandom_range(1, 5);
			repeat (ntok) begin
				kind = $urandom_range(99);
				if (kind < 30)
					raw_q.push_back(8'($urandom_range(1, 255)));
				else if (kind < 50) begin
					// named backslash escape
					raw_q.push_back(esc_pkg::CHR_BSL);
					case ($urandom_range(8))
					0: b = esc_pkg::CHR_LC_A;
					1: b = esc_pkg::CHR_LC_B;
					2: b = esc_pkg::CHR_LC_E;
					3: b = esc_pkg::CHR_UC_E;
					4: b = esc_pkg::CHR_LC_N;
					5: b = esc_pkg::CHR_LC_R;
					6: b = esc_pkg::CHR_LC_T;
					7: b = esc_pkg::CHR_BSL;
					default: b = esc_pkg::CHR_CARET;
					endcase
					raw_q.push_back(b);
				end else if (kind < 65) begin
					// octal run of one to three digits
					raw_q.push_back(esc_pkg::CHR_BSL);
					ndig = $urandom_range(1, 3);
					repeat (ndig) begin
						b = esc_pkg::CHR_ZERO + 8'($urandom_range(0, 7));
						raw_q.push_back(b);
					end
				end else if (kind < 80) begin
					// caret with a letter of either case, or a question mark
					raw_q.push_back(esc_pkg::CHR_CARET);
					if ($urandom_range(7) == 0)
						b = esc_pkg::CHR_QMARK;
					else begin
						b = 8'($urandom_range(esc_pkg::CHR_UC_A, esc_pkg::CHR_UC_Z));
						if ($urandom_range(1))
							b = b + (esc_pkg::CHR_LC_A - esc_pkg::CHR_UC_A);
					end
					raw_q.push_back(b);
				end else if (kind < 92) begin
					// escape char before any nonzero byte
					raw_q.push_back($urandom_range(1) ? esc_pkg::CHR_BSL : esc_pkg::CHR_CARET);
					raw_q.push_back(8'($urandom_range(1, 255)));
				end else if (kind < 98)
					raw_q.push_back(8'($urandom_range(0, 255)));
				else
					raw_q.push_back($urandom_range(1) ? esc_pkg::CHR_BSL : esc_pkg::CHR_CARET);
			end
			send_string();
		end
		quiet = 1'b0;
		in_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("sent %0d raw bytes in %0d strings, compared %0d decoded bytes",
			bytes_sent, strings_sent, decoded_count);
		$display("escapes, octal runs, lone escapes at end, idle gaps and stalls on both sides");
		if (fail_count == 0)
			$display("escape_sequence_unescaper_tb: clean");
		else
			$display("escape_sequence_unescaper_tb: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/esc_pkg.sv
rtl/esc_decode.sv
rtl/esc_outq.sv
rtl/escape_sequence_unescaper.sv
test/unescape_checker.sv
test/escape_sequence_unescaper_tb.sv
